/* rtl/rtcrf_pkg.sv */
// shared types, register map codes and bcd helpers for the rtc register file
package rtcrf_pkg;

   // input action codes
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // command codes between front and back
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   // register map
   localparam logic [7:0] REG_SECONDS     = 8'h00;
   localparam logic [7:0] REG_MINUTES     = 8'h01;
   localparam logic [7:0] REG_HOURS       = 8'h02;
   localparam logic [7:0] REG_WEEKDAY     = 8'h03;
   localparam logic [7:0] REG_DATE        = 8'h04;
   localparam logic [7:0] REG_MONTH       = 8'h05;
   localparam logic [7:0] REG_YEAR        = 8'h06;
   localparam logic [7:0] REG_ALARM_FIRST = 8'h07;
   localparam logic [7:0] REG_ALARM_LAST  = 8'h0D;
   localparam logic [7:0] REG_CONTROL     = 8'h0E;
   localparam logic [7:0] REG_STATUS      = 8'h0F;
   localparam logic [7:0] REG_TEMP_MSB    = 8'h11;
   localparam logic [7:0] REG_TEMP_LSB    = 8'h12;

   // control byte bits
   localparam int CTRL_A1IE_BIT  = 0;
   localparam int CTRL_A2IE_BIT  = 1;
   localparam int CTRL_INTCN_BIT = 2;
   localparam int CTRL_EOSC_BIT  = 7;

   // reset values
   localparam logic signed [9:0] TEMP_RESET    = 10'sd100;
   localparam logic [4:0]        HOURS_RESET   = 5'd12;
   localparam logic [7:0]        YEAR_RESET    = 8'd24;
   localparam logic [7:0]        ALARM_RESET   = 8'h80;
   localparam int                ALARM_COUNT   = 7;

   // default queue depths
   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   // command from front to back
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] addr;
      logic [7:0] data;
   } cmd_type;

   // result from back to output queue
   typedef struct packed {
      logic [7:0] read_data;
      logic       sqw_level;
   } rsp_type;

   // binary to bcd, tens digit cut to four bits
   function automatic logic [7:0] to_bcd(input logic [7:0] value);
      logic [15:0] product;
      logic [4:0]  tens;
      logic [7:0]  units;
      product = {8'd0, value} * 16'd205;
      tens    = product[15:11];
      units   = value - 8'({3'd0, tens} * 8'd10);
      return {tens[3:0], units[3:0]};
   endfunction

   // bcd to binary
   function automatic logic [7:0] from_bcd(input logic [7:0] value);
      logic [7:0] high;
      high = {4'd0, value[7:4]};
      return {4'd0, value[3:0]} + (high << 3) + (high << 1);
   endfunction

endpackage

/* rtl/rtcrf_fifo.sv */
// small first-in first-out queue with registered storage
module rtcrf_fifo
   import rtcrf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   storage_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = storage_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (do_push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/rtcrf_front.sv */
// front end: owns the register pointer and turns bus items into commands
module rtcrf_front
   import rtcrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] action,
   input  logic [7:0] data_byte,
   input  logic       first_of_write,
   output cmd_type    cmd
);

   logic [7:0] pointer_ff, pointer_in;

   // classify the item and advance the pointer
   always_comb begin
      pointer_in = pointer_ff;
      cmd.op     = OP_NONE;
      cmd.addr   = pointer_ff;
      cmd.data   = data_byte;
      unique case (action)
         ACT_WRITE: begin
            if (first_of_write) begin
               pointer_in = data_byte;
            end else begin
               cmd.op     = OP_WRITE;
               pointer_in = pointer_ff + 8'd1;
            end
         end
         ACT_READ: begin
            cmd.op     = OP_READ;
            pointer_in = pointer_ff + 8'd1;
         end
         ACT_TICK: begin
            cmd.op = OP_TICK;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
      end else if (accept) begin
         pointer_ff <= pointer_in;
      end
   end

endmodule

/* rtl/rtcrf_back.sv */
// back end: time keeping, alarm registers and the register map
module rtcrf_back
   import rtcrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [9:0] csr_write_data,
   input  logic       execute,
   input  cmd_type    cmd,
   output rsp_type    rsp
);

   logic signed [9:0] temp_ff;
   logic [5:0] seconds_ff, seconds_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [4:0] hours_ff, hours_in;
   logic [5:0] date_ff, date_in;
   logic [4:0] month_ff, month_in;
   logic [7:0] year_ff, year_in;
   logic [2:0] weekday_ff, weekday_in;
   logic [7:0] alarm_ff [ALARM_COUNT];
   logic [7:0] alarm_in [ALARM_COUNT];
   logic [7:0] control_ff, control_in;
   logic [1:0] flags_ff, flags_in;
   logic       osc_ff, osc_in;
   logic       square_ff, square_in;
   logic       phase_ff, phase_in;

   logic [7:0] wr_sec, wr_hour, wr_date, wr_month;
   logic [2:0] alarm_idx;
   logic [5:0] tick_sec, tick_min;
   logic [4:0] tick_hour;
   logic [7:0] bcd_sec, bcd_min, bcd_hour, bcd_date;
   logic       match1, match2;
   logic [7:0] read_data;

   assign alarm_idx = 3'(cmd.addr[3:0] - 4'd7);

   // decoded write values
   always_comb begin
      wr_sec = from_bcd({1'b0, cmd.data[6:0]});
      if (wr_sec >= 8'd60) begin
         wr_sec = wr_sec - 8'd60;
      end
      wr_hour = from_bcd({2'b0, cmd.data[5:0]});
      if (wr_hour >= 8'd24) begin
         wr_hour = wr_hour - 8'd24;
      end
      wr_date  = from_bcd({2'b0, cmd.data[5:0]});
      wr_month = from_bcd({3'b0, cmd.data[4:0]});
   end

   // time after a whole second
   always_comb begin
      tick_sec  = seconds_ff + 6'd1;
      tick_min  = minutes_ff;
      tick_hour = hours_ff;
      if (seconds_ff >= 6'd59) begin
         tick_sec = '0;
         tick_min = minutes_ff + 6'd1;
         if (minutes_ff >= 6'd59) begin
            tick_min  = '0;
            tick_hour = (hours_ff >= 5'd23) ? 5'd0 : hours_ff + 5'd1;
         end
      end
   end

   // alarm compare on the advanced time
   always_comb begin
      bcd_sec  = to_bcd({2'b0, tick_sec}) & 8'h7F;
      bcd_min  = to_bcd({2'b0, tick_min}) & 8'h7F;
      bcd_hour = to_bcd({3'b0, tick_hour}) & 8'h3F;
      bcd_date = to_bcd({2'b0, date_ff}) & 8'h3F;
      match1 = !alarm_ff[0][7] && !alarm_ff[1][7] && !alarm_ff[2][7] && !alarm_ff[3][7]
               && bcd_sec == (alarm_ff[0] & 8'h7F) && bcd_min == (alarm_ff[1] & 8'h7F)
               && bcd_hour == (alarm_ff[2] & 8'h3F) && bcd_date == (alarm_ff[3] & 8'h3F);
      match2 = !alarm_ff[4][7] && !alarm_ff[5][7] && !alarm_ff[6][7]
               && bcd_min == (alarm_ff[4] & 8'h7F) && bcd_hour == (alarm_ff[5] & 8'h3F)
               && bcd_date == (alarm_ff[6] & 8'h3F);
   end

   // register read mux
   always_comb begin
      unique case (cmd.addr) inside
         REG_SECONDS: read_data = to_bcd({2'b0, seconds_ff}) | (osc_ff ? 8'h00 : 8'h80);
         REG_MINUTES: read_data = to_bcd({2'b0, minutes_ff});
         REG_HOURS:   read_data = to_bcd({3'b0, hours_ff}) & 8'h3F;
         REG_WEEKDAY: read_data = {5'd0, (weekday_ff != 3'd0) ? weekday_ff : 3'd1};
         REG_DATE:    read_data = to_bcd({2'b0, date_ff});
         REG_MONTH:   read_data = to_bcd({3'b0, month_ff});
         REG_YEAR:    read_data = to_bcd(year_ff);
         [REG_ALARM_FIRST:REG_ALARM_LAST]: read_data = alarm_ff[alarm_idx];
         REG_CONTROL: read_data = control_ff;
         REG_STATUS:  read_data = {6'd0, flags_ff};
         REG_TEMP_MSB: read_data = temp_ff[9:2];
         REG_TEMP_LSB: read_data = {temp_ff[1:0], 6'd0};
         default:     read_data = 8'h00;
      endcase
   end

   // next state for one command
   always_comb begin
      seconds_in = seconds_ff;
      minutes_in = minutes_ff;
      hours_in   = hours_ff;
      date_in    = date_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      weekday_in = weekday_ff;
      alarm_in   = alarm_ff;
      control_in = control_ff;
      flags_in   = flags_ff;
      osc_in     = osc_ff;
      square_in  = square_ff;
      phase_in   = phase_ff;
      rsp.read_data = 8'h00;
      if (execute) begin
         case (cmd.op)
            OP_WRITE: begin
               unique case (cmd.addr) inside
                  REG_SECONDS: begin
                     osc_in     = !cmd.data[CTRL_EOSC_BIT];
                     seconds_in = wr_sec[5:0];
                     phase_in   = 1'b0;
                  end
                  REG_MINUTES: begin
                     minutes_in = wr_sec[5:0];
                     phase_in   = 1'b0;
                  end
                  REG_HOURS: begin
                     hours_in = wr_hour[4:0];
                     phase_in = 1'b0;
                  end
                  REG_WEEKDAY: weekday_in = (cmd.data == 8'd0) ? 3'd1 : cmd.data[2:0];
                  REG_DATE:    date_in = (wr_date == 8'd0) ? 6'd1 : wr_date[5:0];
                  REG_MONTH:   month_in = (wr_month == 8'd0) ? 5'd1 : wr_month[4:0];
                  REG_YEAR:    year_in = from_bcd(cmd.data);
                  [REG_ALARM_FIRST:REG_ALARM_LAST]: alarm_in[alarm_idx] = cmd.data;
                  REG_CONTROL: begin
                     control_in = cmd.data;
                     osc_in     = !cmd.data[CTRL_EOSC_BIT];
                  end
                  REG_STATUS: flags_in = flags_ff & ~cmd.data[1:0];
                  default: ;
               endcase
            end
            OP_READ: begin
               rsp.read_data = read_data;
            end
            OP_TICK: begin
               if (osc_ff) begin
                  if (!control_ff[CTRL_INTCN_BIT]) begin
                     square_in = !square_ff;
                  end
                  phase_in = !phase_ff;
                  if (phase_ff) begin
                     seconds_in = tick_sec;
                     minutes_in = tick_min;
                     hours_in   = tick_hour;
                     flags_in   = flags_ff | {match2, match1};
                  end
               end
            end
            default: ;
         endcase
      end
      // pin level after the command
      if (control_in[CTRL_INTCN_BIT]) begin
         rsp.sqw_level = !((control_in[CTRL_A1IE_BIT] && flags_in[0]) ||
                           (control_in[CTRL_A2IE_BIT] && flags_in[1]));
      end else begin
         rsp.sqw_level = square_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff    <= TEMP_RESET;
         seconds_ff <= '0;
         minutes_ff <= '0;
         hours_ff   <= HOURS_RESET;
         date_ff    <= 6'd1;
         month_ff   <= 5'd1;
         year_ff    <= YEAR_RESET;
         weekday_ff <= 3'd1;
         for (int i = 0; i < ALARM_COUNT; i++) begin
            alarm_ff[i] <= ALARM_RESET;
         end
         control_ff <= '0;
         flags_ff   <= '0;
         osc_ff     <= 1'b1;
         square_ff  <= 1'b0;
         phase_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            temp_ff <= csr_write_data;
         end
         seconds_ff <= seconds_in;
         minutes_ff <= minutes_in;
         hours_ff   <= hours_in;
         date_ff    <= date_in;
         month_ff   <= month_in;
         year_ff    <= year_in;
         weekday_ff <= weekday_in;
         alarm_ff   <= alarm_in;
         control_ff <= control_in;
         flags_ff   <= flags_in;
         osc_ff     <= osc_in;
         square_ff  <= square_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

/* rtl/rtc_register_file_with_alarms.sv */
// top level: rtc register file with two alarms behind a byte bus
//
//   channel   ports                                            transfer when
//   request   push, full, req_action, req_data_byte,
//             req_first_of_write                               push && !full
//   response  empty, pop, rsp_read_data, rsp_sqw_level         pop && !empty
//   csr       csr_write_enable, csr_write_data                 csr_write_enable
//
// one item per cycle sustained while neither queue is full; a result reaches the response
// ports through the command queue, the back end and then the registered response queue.
// the back end executes one command per cycle and stalls only on a full
// response queue; the request side stalls only on a full command queue.
// synchronous reset clears both queues, the pointer and all clock state.
module rtc_register_file_with_alarms
   import rtcrf_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_write,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_read_data,
   output logic       rsp_sqw_level,
   input  logic       csr_write_enable,
   input  logic [9:0] csr_write_data
);

   cmd_type front_cmd, back_cmd;
   rsp_type back_rsp, head_rsp;
   logic    req_accept;
   logic    cmd_empty, rsp_full, execute;

   assign req_accept = push && !full;
   assign execute    = !cmd_empty && !rsp_full;

   // request side
   rtcrf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .action         (req_action),
      .data_byte      (req_data_byte),
      .first_of_write (req_first_of_write),
      .cmd            (front_cmd)
   );

   // command queue between front and back
   rtcrf_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cmd),
      .pop       (execute),
      .head_data (back_cmd),
      .full      (full),
      .empty     (cmd_empty)
   );

   // register file and time keeping
   rtcrf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .execute          (execute),
      .cmd              (back_cmd),
      .rsp              (back_rsp)
   );

   // response queue
   rtcrf_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (execute),
      .push_data (back_rsp),
      .pop       (pop),
      .head_data (head_rsp),
      .full      (rsp_full),
      .empty     (empty)
   );

   assign rsp_read_data = head_rsp.read_data;
   assign rsp_sqw_level = head_rsp.sqw_level;

endmodule

/* sim/rtc_time_keeper_pkg.sv */
// scoreboard class that mirrors the rtc register file and checks every result transfer
package rtc_time_keeper_pkg;
   import rtcrf_pkg::*;

   // action code that the block leaves alone
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       first_of_write;
   } bus_item_type;

   class rtc_time_keeper;
      logic [9:0] temperature;
      logic [5:0] seconds;
      logic [5:0] minutes;
      logic [4:0] hours;
      logic [5:0] date;
      logic [4:0] month;
      logic [7:0] year;
      logic [2:0] weekday;
      logic [7:0] alarm [ALARM_COUNT];
      logic [7:0] control;
      logic [1:0] flags;
      logic [7:0] pointer;
      logic       osc_on;
      logic       square;
      logic       phase;

      rsp_type expected_results[$];

      int mismatches;
      int reads;
      int data_writes;
      int pointer_loads;
      int ticks;
      int unused_actions;
      int alarm1_matches;
      int alarm2_matches;
      int hour_carries;

      // state right after reset
      function new();
         temperature = TEMP_RESET;
         seconds     = '0;
         minutes     = '0;
         hours       = HOURS_RESET;
         date        = 6'd1;
         month       = 5'd1;
         year        = YEAR_RESET;
         weekday     = 3'd1;
         foreach (alarm[i]) alarm[i] = ALARM_RESET;
         control     = '0;
         flags       = '0;
         pointer     = '0;
         osc_on      = 1'b1;
         square      = 1'b0;
         phase       = 1'b0;
      endfunction

      function int bcd_of(int v);
         return (((v / 10) << 4) | (v % 10)) & 255;
      endfunction

      function int binary_of(int x);
         return (x & 15) + 10 * ((x >> 4) & 15);
      endfunction

      function void set_temperature(logic [9:0] t);
         temperature = t;
      endfunction

      // byte seen by a bus read at register r
      function logic [7:0] register_value(logic [7:0] r);
         logic [7:0] value;
         value = 8'd0;
         case (r)
            REG_SECONDS:  value = 8'(bcd_of(seconds)) | (osc_on ? 8'h00 : 8'h80);
            REG_MINUTES:  value = 8'(bcd_of(minutes));
            REG_HOURS:    value = 8'(bcd_of(hours)) & 8'h3F;
            REG_WEEKDAY:  value = (weekday != 3'd0) ? {5'd0, weekday} : 8'd1;
            REG_DATE:     value = 8'(bcd_of(date));
            REG_MONTH:    value = 8'(bcd_of(month));
            REG_YEAR:     value = 8'(bcd_of(year));
            REG_CONTROL:  value = control;
            REG_STATUS:   value = {6'd0, flags};
            REG_TEMP_MSB: value = temperature[9:2];
            REG_TEMP_LSB: value = {temperature[1:0], 6'd0};
            default: begin
               if (r >= REG_ALARM_FIRST && r <= REG_ALARM_LAST)
                  value = alarm[r - REG_ALARM_FIRST];
            end
         endcase
         return value;
      endfunction

      // effect of a bus data write at register r
      function void write_register(logic [7:0] r, logic [7:0] v);
         int t;
         case (r)
            REG_SECONDS: begin
               osc_on  = ~v[7];
               seconds = 6'(binary_of(v & 8'h7F) % 60);
               phase   = 1'b0;
            end
            REG_MINUTES: begin
               minutes = 6'(binary_of(v & 8'h7F) % 60);
               phase   = 1'b0;
            end
            REG_HOURS: begin
               hours = 5'(binary_of(v & 8'h3F) % 24);
               phase = 1'b0;
            end
            REG_WEEKDAY: weekday = (v == 8'd0) ? 3'd1 : v[2:0];
            REG_DATE: begin
               t    = binary_of(v & 8'h3F);
               date = 6'((t < 1) ? 1 : t);
            end
            REG_MONTH: begin
               t     = binary_of(v & 8'h1F);
               month = 5'((t < 1) ? 1 : t);
            end
            REG_YEAR: year = 8'(binary_of(v));
            REG_CONTROL: begin
               control = v;
               osc_on  = ~v[CTRL_EOSC_BIT];
            end
            REG_STATUS: flags = flags & ~v[1:0];
            default: begin
               if (r >= REG_ALARM_FIRST && r <= REG_ALARM_LAST)
                  alarm[r - REG_ALARM_FIRST] = v;
            end
         endcase
      endfunction

      // alarm comparison on each whole second, only with every mask bit clear
      function void compare_alarms();
         logic [7:0] s, m, h, d;
         s = 8'(bcd_of(seconds)) & 8'h7F;
         m = 8'(bcd_of(minutes)) & 8'h7F;
         h = 8'(bcd_of(hours)) & 8'h3F;
         d = 8'(bcd_of(date)) & 8'h3F;
         if (((alarm[0] | alarm[1] | alarm[2] | alarm[3]) & 8'h80) == 8'h00 &&
             s == (alarm[0] & 8'h7F) && m == (alarm[1] & 8'h7F) &&
             h == (alarm[2] & 8'h3F) && d == (alarm[3] & 8'h3F)) begin
            flags[0] = 1'b1;
            alarm1_matches++;
         end
         if (((alarm[4] | alarm[5] | alarm[6]) & 8'h80) == 8'h00 &&
             m == (alarm[4] & 8'h7F) && h == (alarm[5] & 8'h3F) &&
             d == (alarm[6] & 8'h3F)) begin
            flags[1] = 1'b1;
            alarm2_matches++;
         end
      endfunction

      // half-second tick: square wave, phase, then seconds carry on a whole second
      function void half_second();
         if (!osc_on) return;
         if (!control[CTRL_INTCN_BIT]) square = ~square;
         phase = ~phase;
         if (phase) return;
         if (seconds == 6'd59) begin
            seconds = '0;
            if (minutes == 6'd59) begin
               minutes = '0;
               hours   = (hours == 5'd23) ? 5'd0 : hours + 5'd1;
               hour_carries++;
            end else begin
               minutes = minutes + 6'd1;
            end
         end else begin
            seconds = seconds + 6'd1;
         end
         compare_alarms();
      endfunction

      // sqw/int pin: active-low interrupt or square wave
      function logic pin_level();
         if (control[CTRL_INTCN_BIT])
            return !((control[CTRL_A1IE_BIT] && flags[0]) ||
                     (control[CTRL_A2IE_BIT] && flags[1]));
         return square;
      endfunction

      // update on an accepted bus item and queue the result it causes
      function void note_bus_byte(bus_item_type item);
         rsp_type outcome;
         outcome.read_data = 8'd0;
         case (item.action)
            ACT_WRITE: begin
               if (item.first_of_write) begin
                  pointer = item.data_byte;
                  pointer_loads++;
               end else begin
                  write_register(pointer, item.data_byte);
                  pointer = pointer + 8'd1;
                  data_writes++;
               end
            end
            ACT_READ: begin
               outcome.read_data = register_value(pointer);
               pointer = pointer + 8'd1;
               reads++;
            end
            ACT_TICK: begin
               half_second();
               ticks++;
            end
            default: unused_actions++;
         endcase
         outcome.sqw_level = pin_level();
         expected_results.push_back(outcome);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("%0t: mismatch: %s", $time, what);
      endtask

      // compare one result transfer with the oldest expectation
      task check_bus_result(logic [7:0] read_data, logic sqw_level);
         rsp_type oldest;
         if (expected_results.size() == 0) begin
            report($sformatf("result read_data %02h sqw %0d with nothing expected",
                             read_data, sqw_level));
            return;
         end
         oldest = expected_results.pop_front();
         if (read_data !== oldest.read_data)
            report($sformatf("read_data %02h, expected %02h", read_data, oldest.read_data));
         if (sqw_level !== oldest.sqw_level)
            report($sformatf("sqw_level %0d, expected %0d", sqw_level, oldest.sqw_level));
      endtask
   endclass

endpackage

/* sim/rtc_register_file_with_alarms_test.sv */
// testbench top: drives bus bytes and ticks into the rtc register file and checks each result
module rtc_register_file_with_alarms_test;
   import rtcrf_pkg::*;
   import rtc_time_keeper_pkg::*;

   typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_CADENCE} pop_mode_type;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       push               = 1'b0;
   logic       full;
   logic [1:0] req_action         = ACT_WRITE;
   logic [7:0] req_data_byte      = 8'd0;
   logic       req_first_of_write = 1'b0;
   logic       empty;
   logic       pop                = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_sqw_level;
   logic       csr_write_enable   = 1'b0;
   logic [9:0] csr_write_data     = 10'd0;

   rtc_time_keeper clock_keeper = new();

   int           burst_left           = 0;
   int           items_sent           = 0;
   int           temperature_settings = 1;
   bit           hold_request         = 1'b0;
   int           hold_left            = 0;
   pop_mode_type pop_mode             = POP_ALWAYS;
   int           pop_pattern_left     = 0;
   int           pop_cadence          = 0;
   logic [9:0]   temperature_extremes [4] = '{10'h200, 10'h1FF, 10'h000, 10'h3FF};

   always #2 clock = ~clock;

   rtc_register_file_with_alarms i_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_first_of_write (req_first_of_write),
      .empty              (empty),
      .pop                (pop),
      .rsp_read_data      (rsp_read_data),
      .rsp_sqw_level      (rsp_sqw_level),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         clock_keeper.check_bus_result(rsp_read_data, rsp_sqw_level);
   end

   // receiver: stall pattern of its own, plus one long hold-off when asked
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 80;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop = 1'b0;
      end else begin
         if (pop_pattern_left == 0) begin
            pop_mode         = pop_mode_type'($urandom_range(0, 3));
            pop_pattern_left = $urandom_range(10, 80);
         end
         pop_pattern_left--;
         pop_cadence++;
         case (pop_mode)
            POP_ALWAYS: pop = 1'b1;
            POP_HALF:   pop = 1'($urandom_range(0, 1));
            POP_SPARSE: pop = ($urandom_range(0, 4) == 0);
            default:    pop = (pop_cadence % 3 != 0);
         endcase
      end
   end

   // random values on the request fields while nothing is offered
   task automatic scramble_request();
      req_action         = 2'($urandom);
      req_data_byte      = 8'($urandom);
      req_first_of_write = 1'($urandom);
   endtask

   // offer one item in bursts with random gaps, return once it is transferred
   task automatic send_item(logic [1:0] act, logic [7:0] data, logic first);
      bus_item_type item;
      int           idle_gap;
      bit           ignored;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         repeat (idle_gap) begin
            @(negedge clock);
            push = 1'b0;
            scramble_request();
         end
      end
      @(negedge clock);
      push               = 1'b1;
      req_action         = act;
      req_data_byte      = data;
      req_first_of_write = first;
      item               = {act, data, first};
      do @(posedge clock); while (full);
      ignored = (act == ACT_UNUSED) || (act == ACT_TICK && !clock_keeper.osc_on);
      clock_keeper.note_bus_byte(item);
      if (!ignored) items_sent++;
      burst_left--;
   endtask

   // stop offering and wait until every expected result has been transferred
   task automatic wait_for_results();
      int waited;
      @(negedge clock);
      push = 1'b0;
      scramble_request();
      burst_left = 0;
      waited = 0;
      while (clock_keeper.expected_results.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      if (clock_keeper.expected_results.size() != 0) begin
         clock_keeper.report($sformatf("%0d results still missing after the drain limit",
                                       clock_keeper.expected_results.size()));
         clock_keeper.expected_results.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   // temperature register, written only with the block idle
   task automatic write_temperature(logic [9:0] t);
      wait_for_results();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = t;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data   = 10'($urandom);
      clock_keeper.set_temperature(t);
      temperature_settings++;
   endtask

   function automatic logic [7:0] random_bcd(int low, int high);
      return 8'(clock_keeper.bcd_of($urandom_range(low, high)));
   endfunction

   function automatic logic [7:0] maybe_mask();
      return ($urandom_range(0, 5) == 0) ? 8'h80 : 8'h00;
   endfunction

   function automatic logic [7:0] pick_register();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 18));
   endfunction

   // data byte for the register under the pointer; keep the oscillator mostly running
   function automatic logic [7:0] write_byte_for(logic [7:0] target);
      logic [7:0] v;
      v = $urandom_range(0, 1) ? 8'($urandom) : random_bcd(0, 59);
      if ((target == REG_SECONDS || target == REG_CONTROL) && $urandom_range(0, 5) != 0)
         v[7] = 1'b0;
      return v;
   endfunction

   // run of half-second ticks, usually restarting a stopped oscillator first
   task automatic tick_run(int count);
      if (!clock_keeper.osc_on && $urandom_range(0, 2) != 0) begin
         send_item(ACT_WRITE, REG_CONTROL, 1'b1);
         send_item(ACT_WRITE, clock_keeper.control & 8'h7F, 1'b0);
      end
      repeat (count) send_item(ACT_TICK, 8'($urandom), 1'($urandom));
   endtask

   // time just short of a carry into minutes and hours
   task automatic set_clock_near_rollover();
      send_item(ACT_WRITE, REG_SECONDS, 1'b1);
      send_item(ACT_WRITE, random_bcd(50, 59), 1'b0);
      send_item(ACT_WRITE, $urandom_range(0, 1) ? 8'h59 : random_bcd(0, 59), 1'b0);
      send_item(ACT_WRITE, $urandom_range(0, 1) ? 8'h23 : random_bcd(0, 23), 1'b0);
      tick_run($urandom_range(10, 40));
   endtask

   // both alarms set a few seconds ahead of the current time, then ticks to reach them
   task automatic arm_alarms();
      int         ahead;
      logic [7:0] s, m, h, d;
      logic [7:0] ctrl;
      ahead = $urandom_range(0, 4);
      s = 8'(clock_keeper.bcd_of((clock_keeper.seconds + ahead) % 60));
      m = 8'(clock_keeper.bcd_of(clock_keeper.minutes));
      h = 8'(clock_keeper.bcd_of(clock_keeper.hours));
      d = 8'(clock_keeper.bcd_of(clock_keeper.date)) & 8'h3F;
      send_item(ACT_WRITE, REG_ALARM_FIRST, 1'b1);
      send_item(ACT_WRITE, s | maybe_mask(), 1'b0);
      send_item(ACT_WRITE, m | maybe_mask(), 1'b0);
      send_item(ACT_WRITE, h | maybe_mask() | {1'b0, 1'($urandom), 6'd0}, 1'b0);
      send_item(ACT_WRITE, d | maybe_mask() | {1'b0, 1'($urandom), 6'd0}, 1'b0);
      send_item(ACT_WRITE, m | maybe_mask(), 1'b0);
      send_item(ACT_WRITE, h | maybe_mask() | {1'b0, 1'($urandom), 6'd0}, 1'b0);
      send_item(ACT_WRITE, d | maybe_mask() | {1'b0, 1'($urandom), 6'd0}, 1'b0);
      if ($urandom_range(0, 1)) begin
         ctrl = 8'($urandom);
         ctrl[CTRL_EOSC_BIT]  = 1'b0;
         ctrl[CTRL_INTCN_BIT] = 1'b1;
         send_item(ACT_WRITE, REG_CONTROL, 1'b1);
         send_item(ACT_WRITE, ctrl, 1'b0);
      end
      tick_run(2 * ahead + $urandom_range(2, 6));
   endtask

   // one random bus sequence, mostly well formed
   task automatic random_sequence();
      int         roll;
      logic [7:0] ctrl;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         send_item(ACT_WRITE, pick_register(), 1'b1);
         repeat ($urandom_range(1, 4))
            send_item(ACT_WRITE, write_byte_for(clock_keeper.pointer), 1'b0);
      end else if (roll < 38) begin
         send_item(ACT_WRITE, pick_register(), 1'b1);
         repeat ($urandom_range(1, 8)) send_item(ACT_READ, 8'($urandom), 1'($urandom));
      end else if (roll < 58) begin
         tick_run($urandom_range(1, 30));
      end else if (roll < 66) begin
         set_clock_near_rollover();
      end else if (roll < 76) begin
         arm_alarms();
      end else if (roll < 82) begin
         ctrl = 8'($urandom);
         ctrl[CTRL_EOSC_BIT] = ($urandom_range(0, 7) == 0);
         send_item(ACT_WRITE, REG_CONTROL, 1'b1);
         send_item(ACT_WRITE, ctrl, 1'b0);
      end else if (roll < 87) begin
         send_item(ACT_WRITE, REG_STATUS, 1'b1);
         send_item(ACT_WRITE, 8'($urandom), 1'b0);
      end else if (roll < 93) begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1))
               send_item(ACT_READ, 8'($urandom), 1'($urandom));
            else
               send_item(ACT_WRITE, write_byte_for(clock_keeper.pointer), 1'b0);
         end
      end else begin
         repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   // stimulus: directed opening, then six temperature phases of random sequences
   initial begin
      int phase_target;
      scramble_request();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // whole register map at reset, temperature included
      repeat (19) send_item(ACT_READ, 8'h00, 1'b0);
      // pointer at the top address, unmapped write, wrap to seconds
      send_item(ACT_WRITE, 8'hFF, 1'b1);
      send_item(ACT_WRITE, 8'h00, 1'b0);
      // stop the oscillator through the seconds register, tick is ignored
      send_item(ACT_WRITE, 8'h80, 1'b0);
      send_item(ACT_TICK, 8'hFF, 1'b1);
      send_item(ACT_UNUSED, 8'hFF, 1'b1);

      for (int p = 0; p < 6; p++) begin
         write_temperature(p < 4 ? temperature_extremes[p] : 10'($urandom));
         if (p == 2) hold_request = 1'b1;
         phase_target = items_sent + 275;
         while (items_sent < phase_target) random_sequence();
      end

      wait_for_results();
      $display("covered %0d reads, %0d data writes, %0d pointer loads, %0d ticks, %0d unused",
               clock_keeper.reads, clock_keeper.data_writes, clock_keeper.pointer_loads,
               clock_keeper.ticks, clock_keeper.unused_actions);
      $display("alarm 1 hit %0d times, alarm 2 %0d times, %0d hour carries, %0d temperatures",
               clock_keeper.alarm1_matches, clock_keeper.alarm2_matches,
               clock_keeper.hour_carries, temperature_settings);
      if (clock_keeper.mismatches == 0)
         $display("rtc_register_file_with_alarms test passed");
      else
         $display("rtc_register_file_with_alarms test failed");
      $finish;
   end

   // run limit
   initial begin
      #1_600_000;
      $display("rtc_register_file_with_alarms test failed");
      $finish;
   end

endmodule
